// ----- hw/rtl/colt_pkg.sv -----
// ----------------------------------------------------------------------------
// colt_pkg
// Shared types and codes of the cursor overlay lock tracker.
// ----------------------------------------------------------------------------
package colt_pkg;

  localparam int DIM_BITS = 13;

  typedef enum logic [2:0] {
    REQ_SHAPE  = 3'd0,
    REQ_MOVE   = 3'd1,
    REQ_LOCK   = 3'd2,
    REQ_UNLOCK = 3'd3,
    REQ_FREE   = 3'd4
  } req_t;

  localparam logic ACT_RESTORE = 1'b0;
  localparam logic ACT_DRAW    = 1'b1;

  localparam logic [1:0] CFG_DESKTOP_W = 2'd0;
  localparam logic [1:0] CFG_DESKTOP_H = 2'd1;
  localparam logic [1:0] CFG_SHAPE_EN  = 2'd2;

  localparam logic [DIM_BITS-1:0] DESKTOP_W_RST = 13'd1024;
  localparam logic [DIM_BITS-1:0] DESKTOP_H_RST = 13'd768;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic                shape_en;
  } cfg_t;

  typedef struct packed {
    logic                action;
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic                last;
  } cmd_t;

endpackage

// ----- hw/rtl/cursor_overlay_lock_tracker_core.sv -----
// ----------------------------------------------------------------------------
// cursor_overlay_lock_tracker_core
// Software cursor tracker: events in, clipped restore and draw commands out.
// ----------------------------------------------------------------------------
// Each input beat is one cursor event (shape set, move, lock, unlock, free)
// and yields zero, one or two output beats, the last one marked by tlast.
// An event that yields two commands keeps the next event waiting until its
// second command is issued, since the output register issues one command per beat.
// A command reaches the output register by way of the input register and the
// tracker's pending commands. Configuration writes are taken at any time but
// must only be made while no event is in flight.
module cursor_overlay_lock_tracker_core #(
  parameter int COORD_BITS = 14
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // rect_x, rect_y, rect_w, rect_h, zero padding
  input  logic [8*((2*COORD_BITS+2*colt_pkg::DIM_BITS+7)/8)-1:0] s_tdata,
  // req_type
  input  logic [2:0]                               s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // out_x, out_y, out_w, out_h, zero padding
  output logic [8*((4*colt_pkg::DIM_BITS+7)/8)-1:0] m_tdata,
  // action
  output logic                                     m_tuser,
  output logic                                     m_tlast,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [1:0]                               cfg_index,
  input  logic [colt_pkg::DIM_BITS-1:0]            cfg_data
);
  import colt_pkg::*;

  localparam int S_BITS = 2*COORD_BITS + 2*DIM_BITS;
  localparam int S_PAD  = 8*((S_BITS+7)/8) - S_BITS;
  localparam int M_BITS = 4*DIM_BITS;
  localparam int M_PAD  = 8*((M_BITS+7)/8) - M_BITS;

  cfg_t cfg;

  logic                         in_valid;
  logic [2:0]                   in_type;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic [DIM_BITS-1:0]          in_w, in_h;
  logic                         item_take, cmd_valid, cmd_pop;
  cmd_t                         cmd;

  assign cfg_ready = 1'b1;
  assign s_tready  = !in_valid || item_take;
  assign cmd_pop   = cmd_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= DESKTOP_W_RST;
      cfg.height   <= DESKTOP_H_RST;
      cfg.shape_en <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DESKTOP_W: cfg.width    <= cfg_data;
        CFG_DESKTOP_H: cfg.height   <= cfg_data;
        CFG_SHAPE_EN:  cfg.shape_en <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (item_take) begin
        in_valid <= 1'b0;
      end
      if (cmd_pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type <= s_tuser;
      in_x    <= s_tdata[COORD_BITS-1:0];
      in_y    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      in_w    <= s_tdata[2*COORD_BITS+DIM_BITS-1:2*COORD_BITS];
      in_h    <= s_tdata[S_BITS-1:2*COORD_BITS+DIM_BITS];
    end
    if (cmd_pop) begin
      m_tdata <= {{M_PAD{1'b0}}, cmd.h, cmd.w, cmd.y, cmd.x};
      m_tuser <= cmd.action;
      m_tlast <= cmd.last;
    end
  end

  colt_tracker #(
    .COORD_BITS (COORD_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid),
    .req_type   (in_type),
    .rect_x     (in_x),
    .rect_y     (in_y),
    .rect_w     (in_w),
    .rect_h     (in_h),
    .item_take  (item_take),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  // padding bits of the slave beat carry nothing
  logic unused_pad;
  assign unused_pad = ^{1'b0, s_tdata[S_BITS + S_PAD - 1:S_BITS]};

endmodule

// ----- hw/rtl/colt_tracker.sv -----
// ----------------------------------------------------------------------------
// colt_tracker
// Cursor and lock state, per-event command pair and desktop clipping.
// ----------------------------------------------------------------------------
module colt_tracker #(
  parameter int COORD_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  colt_pkg::cfg_t                 cfg,
  input  logic                           item_valid,
  input  logic [2:0]                     req_type,
  input  logic signed [COORD_BITS-1:0]   rect_x,
  input  logic signed [COORD_BITS-1:0]   rect_y,
  input  logic [colt_pkg::DIM_BITS-1:0]  rect_w,
  input  logic [colt_pkg::DIM_BITS-1:0]  rect_h,
  output logic                           item_take,
  output logic                           cmd_valid,
  output colt_pkg::cmd_t                 cmd,
  input  logic                           cmd_pop
);
  import colt_pkg::*;

  localparam int AW = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 3;
  localparam logic signed [AW-1:0] UNIT = AW'(1);
  localparam logic signed [AW-1:0] ZERO = '0;

  typedef struct packed {
    logic signed [AW-1:0]  x;
    logic signed [AW-1:0]  y;
    logic [DIM_BITS-1:0]   w;
    logic [DIM_BITS-1:0]   h;
  } geo_t;

  logic cursor_valid, cursor_hidden, lock_valid;
  logic cursor_valid_next, cursor_hidden_next, lock_valid_next;
  logic signed [AW-1:0] lock_l, lock_t, lock_r, lock_b;
  logic signed [AW-1:0] lock_l_next, lock_t_next, lock_r_next, lock_b_next;
  logic signed [COORD_BITS-1:0] pos_x, pos_y, pos_x_next, pos_y_next;
  logic [DIM_BITS-1:0] cur_w, cur_h, hot_x, hot_y;
  logic [DIM_BITS-1:0] cur_w_next, cur_h_next, hot_x_next, hot_y_next;

  logic p0, p1;
  geo_t g0, g1;

  logic signed [AW-1:0] ex, ey, ew, eh, ex_r, ey_b, hx, hy, ncx, ncy;
  logic overlap_next, c0, c1, ev_free;
  geo_t geo_old, geo_new, geo_sel;
  logic [2*DIM_BITS-1:0] clip_x, clip_y;

  function automatic logic [2*DIM_BITS-1:0] clip_axis(
    input logic signed [AW-1:0] p,
    input logic [DIM_BITS-1:0]  s,
    input logic [DIM_BITS-1:0]  lim
  );
    logic signed [AW-1:0] a, b, e_lim;
    begin
      a     = p;
      b     = AW'(s);
      e_lim = AW'(lim);
      if (a < ZERO) begin
        b = b + a;
        a = ZERO;
      end else if (a + b > e_lim) begin
        b = e_lim - a;
      end
      if (b < ZERO) begin
        a = ZERO;
        b = ZERO;
      end
      return {b[DIM_BITS-1:0], a[DIM_BITS-1:0]};
    end
  endfunction

  always_comb begin
    ex   = AW'(rect_x);
    ey   = AW'(rect_y);
    ew   = AW'(rect_w);
    eh   = AW'(rect_h);
    ex_r = ex + ew;
    ey_b = ey + eh;
    hx   = (ex < ew - UNIT) ? ex : ew - UNIT;
    hy   = (ey < eh - UNIT) ? ey : eh - UNIT;
    if (hx < ZERO) begin
      hx = ZERO;
    end
    if (hy < ZERO) begin
      hy = ZERO;
    end

    cursor_valid_next  = cursor_valid;
    cursor_hidden_next = cursor_hidden;
    lock_valid_next    = lock_valid;
    lock_l_next        = lock_l;
    lock_t_next        = lock_t;
    lock_r_next        = lock_r;
    lock_b_next        = lock_b;
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    cur_w_next         = cur_w;
    cur_h_next         = cur_h;
    hot_x_next         = hot_x;
    hot_y_next         = hot_y;

    unique case (req_t'(req_type))
      REQ_SHAPE: begin
        if (rect_w != '0 && rect_h != '0 && cfg.shape_en) begin
          cur_w_next = rect_w;
          cur_h_next = rect_h;
          hot_x_next = hx[DIM_BITS-1:0];
          hot_y_next = hy[DIM_BITS-1:0];
        end
      end
      REQ_MOVE: begin
        pos_x_next = rect_x;
        pos_y_next = rect_y;
      end
      REQ_LOCK: begin
        if (!lock_valid) begin
          lock_l_next = ex;
          lock_t_next = ey;
          lock_r_next = ex_r;
          lock_b_next = ey_b;
        end else begin
          lock_l_next = (ex < lock_l) ? ex : lock_l;
          lock_t_next = (ey < lock_t) ? ey : lock_t;
          lock_r_next = (ex_r > lock_r) ? ex_r : lock_r;
          lock_b_next = (ey_b > lock_b) ? ey_b : lock_b;
        end
      end
      default: begin
      end
    endcase

    ncx = AW'(pos_x_next) - AW'(hot_x_next);
    ncy = AW'(pos_y_next) - AW'(hot_y_next);
    overlap_next = (lock_l_next < ncx + $signed(AW'(cur_w_next))) &&
                   (lock_t_next < ncy + $signed(AW'(cur_h_next))) &&
                   (lock_r_next > ncx) && (lock_b_next > ncy);

    c0 = 1'b0;
    c1 = 1'b0;
    unique case (req_t'(req_type))
      REQ_SHAPE: begin
        c0 = cursor_valid && !cursor_hidden;
        cursor_valid_next = 1'b0;
        if (rect_w != '0 && rect_h != '0 && cfg.shape_en) begin
          c1                 = 1'b1;
          cursor_hidden_next = 1'b0;
          lock_valid_next    = 1'b0;
          cursor_valid_next  = 1'b1;
        end
      end
      REQ_MOVE: begin
        if (cursor_valid && !cursor_hidden) begin
          c0                 = 1'b1;
          cursor_hidden_next = 1'b1;
        end
        if (cursor_valid && !(lock_valid && overlap_next)) begin
          c1                 = 1'b1;
          cursor_hidden_next = 1'b0;
        end
      end
      REQ_LOCK: begin
        if (cursor_valid) begin
          lock_valid_next = 1'b1;
          if (!cursor_hidden && overlap_next) begin
            c0                 = 1'b1;
            cursor_hidden_next = 1'b1;
          end
        end else begin
          lock_l_next = lock_l;
          lock_t_next = lock_t;
          lock_r_next = lock_r;
          lock_b_next = lock_b;
        end
      end
      REQ_UNLOCK: begin
        if (cursor_valid) begin
          if (cursor_hidden) begin
            c1                 = 1'b1;
            cursor_hidden_next = 1'b0;
          end
          lock_valid_next = 1'b0;
        end
      end
      REQ_FREE: begin
        c0 = cursor_valid && !cursor_hidden;
        cursor_valid_next = 1'b0;
      end
      default: begin
      end
    endcase

    geo_old.x = AW'(pos_x) - AW'(hot_x);
    geo_old.y = AW'(pos_y) - AW'(hot_y);
    geo_old.w = cur_w;
    geo_old.h = cur_h;
    geo_new.x = ncx;
    geo_new.y = ncy;
    geo_new.w = cur_w_next;
    geo_new.h = cur_h_next;
  end

  assign ev_free   = !(p0 || p1) || (cmd_pop && !(p0 && p1));
  assign item_take = item_valid && ev_free;
  assign cmd_valid = p0 || p1;

  always_comb begin
    geo_sel    = p0 ? g0 : g1;
    clip_x     = clip_axis(geo_sel.x, geo_sel.w, cfg.width);
    clip_y     = clip_axis(geo_sel.y, geo_sel.h, cfg.height);
    cmd.action = p0 ? ACT_RESTORE : ACT_DRAW;
    cmd.x      = clip_x[DIM_BITS-1:0];
    cmd.w      = clip_x[2*DIM_BITS-1:DIM_BITS];
    cmd.y      = clip_y[DIM_BITS-1:0];
    cmd.h      = clip_y[2*DIM_BITS-1:DIM_BITS];
    cmd.last   = p0 ? !p1 : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_valid  <= 1'b0;
      cursor_hidden <= 1'b0;
      lock_valid    <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      cur_w         <= '0;
      cur_h         <= '0;
      hot_x         <= '0;
      hot_y         <= '0;
      p0            <= 1'b0;
      p1            <= 1'b0;
    end else begin
      if (item_take) begin
        cursor_valid  <= cursor_valid_next;
        cursor_hidden <= cursor_hidden_next;
        lock_valid    <= lock_valid_next;
        pos_x         <= pos_x_next;
        pos_y         <= pos_y_next;
        cur_w         <= cur_w_next;
        cur_h         <= cur_h_next;
        hot_x         <= hot_x_next;
        hot_y         <= hot_y_next;
        p0            <= c0;
        p1            <= c1;
      end else if (cmd_pop) begin
        if (p0) begin
          p0 <= 1'b0;
        end else begin
          p1 <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      lock_l <= lock_l_next;
      lock_t <= lock_t_next;
      lock_r <= lock_r_next;
      lock_b <= lock_b_next;
      g0     <= geo_old;
      g1     <= geo_new;
    end
  end

endmodule
